// ----- src/string_to_unsigned_parser_macros.svh -----
// Assertion macros for the string-to-unsigned parser checker.
`ifndef STRING_TO_UNSIGNED_PARSER_MACROS_SVH
`define STRING_TO_UNSIGNED_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define STU_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define STU_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define STU_ASSERT_RST(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/stu_pkg.sv -----
// Shared types, constants and helpers for the string-to-unsigned parser.
`timescale 1ns / 1ps
`default_nettype none

package stu_pkg;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int POS_W   = 16;
    localparam int CH_W    = 8;
    localparam int BASE_W  = 6;
    localparam int PROD_W  = VALUE_W + BASE_W;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Character codes
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;

    // Bases
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    // Digit code for a character that is no digit; not below any base
    localparam logic [BASE_W-1:0] DIG_NONE = '1;

    // Operation the front hands to the back
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_DIGIT  = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    typedef struct packed {
        logic              clr;     // new string: clear accumulator first
        t_op               op;
        logic [BASE_W-1:0] digit;
        logic [BASE_W-1:0] base;
        logic              neg;
        logic              any;     // at least one digit consumed
        logic [POS_W-1:0]  offset;  // end offset, already zero without digits
    } t_cmd;

    // Value of a digit or letter, DIG_NONE for anything else
    function automatic logic [BASE_W-1:0] digit_value(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] d;
        d = '1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - (CH_LA - CH_W'(10));
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = c - (CH_UA - CH_W'(10));
        end
        return (d == '1) ? DIG_NONE : d[BASE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/stu_front.sv -----
// Front end: accepts characters, tracks the string phase and issues commands.
`timescale 1ns / 1ps
`default_nettype none

module stu_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [stu_pkg::CH_W-1:0]   i_ch,
    input  wire logic                       i_start_req,
    input  wire logic [stu_pkg::BASE_W-1:0] i_base,
    input  wire logic                       i_full,
    output logic                            o_push,
    output stu_pkg::t_cmd                   o_cmd
);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_SPACE  = 5'b00010,
        PH_SIGNED = 5'b00100,
        PH_ZERO   = 5'b01000,
        PH_DIGITS = 5'b10000
    } t_phase;

    t_phase                      r_phase, n_phase, ph;
    logic [stu_pkg::BASE_W-1:0]  r_base, n_base, base;
    logic                        r_neg, n_neg, neg;
    logic                        r_any, n_any, any;
    logic [stu_pkg::POS_W-1:0]   r_pos, n_pos, pos;
    logic [stu_pkg::BASE_W-1:0]  dig;
    logic                        take_first, take, accept;
    stu_pkg::t_op                op;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // Phase walk for one character
    always_comb begin
        ph   = r_phase;
        base = r_base;
        neg  = r_neg;
        any  = r_any;
        pos  = r_pos;
        if (i_start_req) begin
            ph   = PH_SPACE;
            base = i_base;
            neg  = 1'b0;
            any  = 1'b0;
            pos  = '0;
        end
        dig        = stu_pkg::digit_value(i_ch);
        n_phase    = ph;
        n_base     = base;
        n_neg      = neg;
        n_any      = any;
        take_first = 1'b0;
        take       = 1'b0;
        op         = stu_pkg::OP_NONE;

        unique case (ph)
            PH_IDLE: begin
            end
            PH_SPACE: begin
                if (i_ch == stu_pkg::CH_SPACE || i_ch == stu_pkg::CH_NL ||
                    i_ch == stu_pkg::CH_TAB) begin
                end else if (i_ch == stu_pkg::CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_SIGNED;
                end else if (i_ch == stu_pkg::CH_PLUS) begin
                    n_phase = PH_SIGNED;
                end else begin
                    take_first = 1'b1;
                end
            end
            PH_SIGNED: begin
                take_first = 1'b1;
            end
            PH_ZERO: begin
                n_phase = PH_DIGITS;
                if (i_ch == stu_pkg::CH_LX || i_ch == stu_pkg::CH_UX) begin
                    n_base = stu_pkg::BASE_HEX;
                end else begin
                    if (base == stu_pkg::BASE_AUTO) begin
                        n_base = stu_pkg::BASE_OCT;
                    end
                    // the leading zero counts as a digit
                    n_any = 1'b1;
                    take  = 1'b1;
                end
            end
            PH_DIGITS: begin
                take = 1'b1;
            end
            default: begin
            end
        endcase

        // First character after space or sign: possible prefix zero
        if (take_first) begin
            if ((base == stu_pkg::BASE_AUTO || base == stu_pkg::BASE_HEX) &&
                i_ch == stu_pkg::CH_ZERO) begin
                n_phase = PH_ZERO;
            end else begin
                if (base == stu_pkg::BASE_AUTO) begin
                    n_base = stu_pkg::BASE_DEC;
                end
                n_phase = PH_DIGITS;
                take    = 1'b1;
            end
        end

        // Digit below base is taken, anything else ends the string
        if (take) begin
            if (dig >= n_base) begin
                op      = stu_pkg::OP_FINISH;
                n_phase = PH_IDLE;
            end else begin
                op    = stu_pkg::OP_DIGIT;
                n_any = 1'b1;
            end
        end

        // Saturating offset counter
        n_pos = pos;
        if (op != stu_pkg::OP_FINISH && ph != PH_IDLE && pos != '1) begin
            n_pos = pos + stu_pkg::POS_W'(1);
        end
    end

    // Command toward the back end
    always_comb begin
        o_cmd.clr    = i_start_req;
        o_cmd.op     = op;
        o_cmd.digit  = dig;
        o_cmd.base   = n_base;
        o_cmd.neg    = n_neg;
        o_cmd.any    = n_any;
        o_cmd.offset = n_any ? pos : '0;
    end

    assign o_push = accept && (i_start_req || op != stu_pkg::OP_NONE);

    // Phase state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_base  <= '0;
            r_neg   <= 1'b0;
            r_any   <= 1'b0;
            r_pos   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_base  <= n_base;
            r_neg   <= n_neg;
            r_any   <= n_any;
            r_pos   <= n_pos;
        end
    end

endmodule

`default_nettype wire

// ----- src/stu_queue.sv -----
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module stu_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire stu_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output stu_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    stu_pkg::t_cmd                 r_mem [stu_pkg::Q_DEPTH];
    logic [stu_pkg::Q_AW-1:0]      r_wptr, r_rptr;
    logic [stu_pkg::Q_CW-1:0]      r_count;
    logic                          do_pop;

    assign o_full  = (r_count == stu_pkg::Q_CW'(stu_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == stu_pkg::Q_AW'(stu_pkg::Q_DEPTH - 1)) ?
                          '0 : r_wptr + stu_pkg::Q_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == stu_pkg::Q_AW'(stu_pkg::Q_DEPTH - 1)) ?
                          '0 : r_rptr + stu_pkg::Q_AW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + stu_pkg::Q_CW'(1);
                2'b01:   r_count <= r_count - stu_pkg::Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/stu_back.sv -----
// Back end: multiply-accumulate with overflow check and result register.
`timescale 1ns / 1ps
`default_nettype none

module stu_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire stu_pkg::t_cmd               i_cmd,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [stu_pkg::VALUE_W-1:0]      o_value,
    output logic [stu_pkg::POS_W-1:0]        o_end_offset,
    output logic                             o_digits_seen,
    output logic                             o_overflow
);

    logic [stu_pkg::VALUE_W-1:0] r_acc, acc_eff, value;
    logic                        r_over, over_eff, mac_ovf;
    logic [stu_pkg::PROD_W-1:0]  prod;
    logic                        r_out_valid, out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_valid && (i_cmd.op != stu_pkg::OP_FINISH || out_free);

    // Accumulator as seen by this command
    assign acc_eff  = i_cmd.clr ? '0 : r_acc;
    assign over_eff = i_cmd.clr ? 1'b0 : r_over;

    // acc * base + digit; any bit above the value width is overflow
    assign prod    = stu_pkg::PROD_W'(acc_eff) * stu_pkg::PROD_W'(i_cmd.base)
                   + stu_pkg::PROD_W'(i_cmd.digit);
    assign mac_ovf = |prod[stu_pkg::PROD_W-1:stu_pkg::VALUE_W];

    // Final value: saturate, else negate on minus
    always_comb begin
        if (over_eff) begin
            value = '1;
        end else if (i_cmd.neg) begin
            value = ~acc_eff + stu_pkg::VALUE_W'(1);
        end else begin
            value = acc_eff;
        end
    end

    // Accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_over <= 1'b0;
        end else if (o_pop) begin
            unique case (i_cmd.op)
                stu_pkg::OP_DIGIT: begin
                    r_over <= over_eff || mac_ovf;
                    r_acc  <= (over_eff || mac_ovf) ?
                              acc_eff : prod[stu_pkg::VALUE_W-1:0];
                end
                stu_pkg::OP_NONE,
                stu_pkg::OP_FINISH: begin
                    r_acc  <= acc_eff;
                    r_over <= over_eff;
                end
                default: begin
                    r_acc  <= r_acc;
                    r_over <= r_over;
                end
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_cmd.op == stu_pkg::OP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == stu_pkg::OP_FINISH) begin
            o_value       <= value;
            o_end_offset  <= i_cmd.offset;
            o_digits_seen <= i_cmd.any;
            o_overflow    <= over_eff;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- src/string_to_unsigned_parser.sv -----
// Top level of the streaming string-to-unsigned parser.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_ch, i_start_req, i_base
//  result    out        o_valid / i_stall   o_value, o_end_offset, o_digits_seen, o_overflow
//
// One character per cycle while o_stall is low; the multiply-add of the back end is combinational.
// The final character's command is queued first; o_valid is registered when the back end pops it.
// Synchronous active-low reset drops any string in progress and the queue.
// o_stall rises only when the two-entry command queue is full, i.e. when a result
// has waited under i_stall; digits keep draining while a result is held.
`timescale 1ns / 1ps
`default_nettype none

module string_to_unsigned_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [stu_pkg::CH_W-1:0]    i_ch,
    input  wire logic                        i_start_req,
    input  wire logic [stu_pkg::BASE_W-1:0]  i_base,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [stu_pkg::VALUE_W-1:0]      o_value,
    output logic [stu_pkg::POS_W-1:0]        o_end_offset,
    output logic                             o_digits_seen,
    output logic                             o_overflow
);

    stu_pkg::t_cmd push_cmd, head_cmd;
    logic          push, q_full, q_valid, pop;

    // Character classification and phase tracking
    stu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_ch        (i_ch),
        .i_start_req (i_start_req),
        .i_base      (i_base),
        .i_full      (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Decoupling queue
    stu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    // Accumulation and result
    stu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value       (o_value),
        .o_end_offset  (o_end_offset),
        .o_digits_seen (o_digits_seen),
        .o_overflow    (o_overflow)
    );

endmodule

`default_nettype wire

// ----- src/stu_checker.sv -----
// Port-level checker for the string-to-unsigned parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "string_to_unsigned_parser_macros.svh"

module stu_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        o_stall,
    input  wire logic [stu_pkg::CH_W-1:0]    i_ch,
    input  wire logic                        i_start_req,
    input  wire logic [stu_pkg::BASE_W-1:0]  i_base,
    input  wire logic                        o_valid,
    input  wire logic                        i_stall,
    input  wire logic [stu_pkg::VALUE_W-1:0] o_value,
    input  wire logic [stu_pkg::POS_W-1:0]   o_end_offset,
    input  wire logic                        o_digits_seen,
    input  wire logic                        o_overflow
);

    // No result leaves right after reset
    `STU_ASSERT_RST(a_rst_quiet, !i_rst_n, !o_valid, "result valid right after reset")

    // A held result keeps its value and end offset
    `STU_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(o_value) && $stable(o_end_offset), "stalled result changed")

    // Saturation shows as all ones and implies digits
    `STU_ASSERT_IMP(a_sat, o_valid && o_overflow, o_digits_seen && (o_value == '1), "overflow without saturated value")

    // Without digits the result is empty
    `STU_ASSERT_IMP(a_empty, o_valid && !o_digits_seen, (o_value == '0) && (o_end_offset == '0) && !o_overflow, "empty string gave nonzero result")

endmodule

bind string_to_unsigned_parser stu_checker u_stu_checker (.*);

`default_nettype wire
